### hdl/tcp_segment_header_builder_assert.svh
// Assertion macros for the TCP segment header builder checker.
// Needs a clk_i and an active-low rst_ni in the scope of each use.
`ifndef TCP_SEGMENT_HEADER_BUILDER_ASSERT_SVH
`define TCP_SEGMENT_HEADER_BUILDER_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define TSHB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TSHB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/tshb_pkg.sv
// Shared types, constants, checksum and flag helpers for the TCP header builder.
// No dependencies.
`default_nettype none

package tshb_pkg;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int HDR_WORDS  = 10;
  localparam int IDX_W      = 4;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HDR_WORDS - 1);

  localparam logic [15:0] HDR_BYTES   = 16'd20;
  localparam logic [7:0]  DATA_OFFSET = 8'h50;
  localparam logic [15:0] PROTO_TCP   = 16'h0006;
  localparam logic [15:0] WINDOW      = 16'h0001;
  localparam logic [15:0] URGENT      = 16'h0000;

  localparam logic [2:0] SEG_SYN     = 3'd1;
  localparam logic [2:0] SEG_SYN_ACK = 3'd2;
  localparam logic [2:0] SEG_ACK     = 3'd3;
  localparam logic [2:0] SEG_FIN     = 3'd4;
  localparam logic [2:0] SEG_FIN_ACK = 3'd5;

  localparam logic [7:0] FLAGS_SYN     = 8'h02;
  localparam logic [7:0] FLAGS_SYN_ACK = 8'h12;
  localparam logic [7:0] FLAGS_ACK     = 8'h10;
  localparam logic [7:0] FLAGS_FIN     = 8'h01;
  localparam logic [7:0] FLAGS_FIN_ACK = 8'h11;
  localparam logic [7:0] FLAGS_NONE    = 8'h00;

  localparam logic [15:0] LOCAL_PORT_RST  = 16'd2007;
  localparam logic [15:0] REMOTE_PORT_RST = 16'd2006;

  localparam logic [15:0] FUNC_OPEN = 16'd0;

  typedef enum logic [1:0] {
    CFG_LOCAL_PORT     = 2'd0,
    CFG_REMOTE_PORT    = 2'd1,
    CFG_LOCAL_ADDRESS  = 2'd2,
    CFG_REMOTE_ADDRESS = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [31:0] local_address;
    logic [31:0] remote_address;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  seg_type;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [10:0] payload_len;
    logic [15:0] psum;
  } job_t;

  function automatic logic [15:0] ones_add3(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] c);
    logic [17:0] s;
    logic [16:0] t;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    t = {1'b0, s[15:0]} + {15'd0, s[17:16]};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  function automatic logic [7:0] flag_byte(input logic [2:0] t);
    logic [7:0] f;
    case (t)
      SEG_SYN:     f = FLAGS_SYN;
      SEG_SYN_ACK: f = FLAGS_SYN_ACK;
      SEG_ACK:     f = FLAGS_ACK;
      SEG_FIN:     f = FLAGS_FIN;
      SEG_FIN_ACK: f = FLAGS_FIN_ACK;
      default:     f = FLAGS_NONE;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

### hdl/tshb_in_if.sv
// Input channel of the TCP header builder: segment opens and payload words.
// No dependencies.
`default_nettype none

interface tshb_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [2:0]  seg_type;
  logic [31:0] seq_num;
  logic [31:0] ack_num;
  logic [10:0] payload_len;
  logic [15:0] payload_word;
  logic        word_last;

  modport source (output valid, func, seg_type, seq_num, ack_num, payload_len,
                  payload_word, word_last, input ready);
  modport sink   (input valid, func, seg_type, seq_num, ack_num, payload_len,
                  payload_word, word_last, output ready);
endinterface

`default_nettype wire

### hdl/tshb_out_if.sv
// Output channel of the TCP header builder: one header word per beat.
// No dependencies.
`default_nettype none

interface tshb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] header_word;
  logic [3:0]  word_index;
  logic        header_last;

  modport source (output valid, header_word, word_index, header_last, input ready);
  modport sink   (input valid, header_word, word_index, header_last, output ready);
endinterface

`default_nettype wire

### hdl/tcp_segment_header_builder.sv
// TCP segment header builder: accepts one input beat per cycle (segment opens and
// payload words summed on the fly) while the two-entry job queue has room, and
// emits ten header beats per segment, one per cycle while a job is queued and the
// output is ready, with the Internet checksum over header, IPv4 pseudo-header and
// payload in word 8. Output throughput is set by the back end's single output
// register. Config registers are read while the header is emitted. Uses tshb_pkg
// and both channel interfaces; instantiates tshb_front, tshb_fifo and tshb_back.
`default_nettype none

module tcp_segment_header_builder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  tshb_in_if.sink          in_i,
  tshb_out_if.source       out_o
);

  tshb_pkg::cfg_t cfg_q, cfg_d;
  tshb_pkg::job_t push_job;
  tshb_pkg::job_t head_job;
  logic           push;
  logic           full;
  logic           head_valid;
  logic           pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tshb_pkg::CFG_LOCAL_PORT:     cfg_d.local_port     = cfg_wdata_i[15:0];
        tshb_pkg::CFG_REMOTE_PORT:    cfg_d.remote_port    = cfg_wdata_i[15:0];
        tshb_pkg::CFG_LOCAL_ADDRESS:  cfg_d.local_address  = cfg_wdata_i;
        tshb_pkg::CFG_REMOTE_ADDRESS: cfg_d.remote_address = cfg_wdata_i;
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{local_port: tshb_pkg::LOCAL_PORT_RST, remote_port: tshb_pkg::REMOTE_PORT_RST,
                 local_address: 32'd0, remote_address: 32'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tshb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .job_o  (push_job),
    .push_o (push)
  );

  tshb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .valid_o (head_valid),
    .pop_i   (pop),
    .job_o   (head_job)
  );

  tshb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .job_i   (head_job),
    .cfg_i   (cfg_q),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

### hdl/tshb_front.sv
// Front end: accepts input beats, tracks the open segment, sums payload words.
// Uses tshb_pkg and tshb_in_if; pushes finished jobs toward tshb_fifo.
`default_nettype none

module tshb_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  tshb_in_if.sink            in_i,
  input  wire logic          full_i,
  output tshb_pkg::job_t     job_o,
  output logic               push_o
);

  logic        open_q, open_d;
  logic [2:0]  type_q, type_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] ack_q, ack_d;
  logic [10:0] len_q, len_d;
  logic [15:0] sum_q, sum_d;
  logic        fire;
  logic        is_open_beat;
  logic [15:0] sum_next;

  assign in_i.ready   = !full_i;
  assign fire         = in_i.valid && in_i.ready;
  assign is_open_beat = in_i.func == tshb_pkg::FUNC_OPEN[0];
  assign sum_next     = tshb_pkg::ones_add3(sum_q, in_i.payload_word, 16'd0);

  always_comb begin
    open_d = open_q;
    type_d = type_q;
    seq_d  = seq_q;
    ack_d  = ack_q;
    len_d  = len_q;
    sum_d  = sum_q;
    push_o = 1'b0;
    job_o  = '{seg_type: type_q, seq_num: seq_q, ack_num: ack_q,
               payload_len: len_q, psum: sum_next};
    if (fire) begin
      if (is_open_beat) begin
        type_d = in_i.seg_type;
        seq_d  = in_i.seq_num;
        ack_d  = in_i.ack_num;
        len_d  = in_i.payload_len;
        sum_d  = 16'd0;
        job_o  = '{seg_type: in_i.seg_type, seq_num: in_i.seq_num,
                   ack_num: in_i.ack_num, payload_len: in_i.payload_len, psum: 16'd0};
        if (in_i.payload_len == 11'd0) begin
          open_d = 1'b0;
          push_o = 1'b1;
        end else begin
          open_d = 1'b1;
        end
      end else if (open_q) begin
        if (in_i.word_last) begin
          open_d = 1'b0;
          sum_d  = 16'd0;
          push_o = 1'b1;
        end else begin
          sum_d = sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else begin
      open_q <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q <= type_d;
    seq_q  <= seq_d;
    ack_q  <= ack_d;
    len_q  <= len_d;
    sum_q  <= sum_d;
  end

endmodule

`default_nettype wire

### hdl/tshb_fifo.sv
// Short job queue between front and back ends of the TCP header builder.
// Uses tshb_pkg for the job type and depth.
`default_nettype none

module tshb_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  tshb_pkg::job_t      job_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output tshb_pkg::job_t      job_o
);

  localparam int AW = tshb_pkg::FIFO_AW;

  tshb_pkg::job_t          mem_q [tshb_pkg::FIFO_DEPTH];
  logic [AW-1:0]           wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [AW:0]             cnt_q, cnt_d;
  logic                    do_push;
  logic                    do_pop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(tshb_pkg::FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full_o  = cnt_q == (AW + 1)'(tshb_pkg::FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

### hdl/tshb_back.sv
// Back end: walks the ten header words of the head job and folds the checksum.
// Uses tshb_pkg and tshb_out_if; reads jobs from tshb_fifo.
`default_nettype none

module tshb_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  tshb_pkg::job_t     job_i,
  input  tshb_pkg::cfg_t     cfg_i,
  output logic               pop_o,
  tshb_out_if.source         out_o
);

  localparam int IW = tshb_pkg::IDX_W;

  logic [IW-1:0] idx_q, idx_d;
  logic [15:0]   acc_q, acc_d;
  logic          ovalid_q, ovalid_d;
  logic [15:0]   oword_q;
  logic [IW-1:0] oidx_q;
  logic          olast_q;
  logic          load;
  logic [15:0]   word;
  logic [15:0]   term;
  logic [15:0]   acc_in;
  logic [15:0]   len_total;

  assign load      = valid_i && (!ovalid_q || out_o.ready);
  assign pop_o     = load && (idx_q == tshb_pkg::IDX_LAST);
  assign acc_in    = (idx_q == '0) ? job_i.psum : acc_q;
  assign len_total = {5'd0, job_i.payload_len} + tshb_pkg::HDR_BYTES;

  always_comb begin
    word = 16'd0;
    term = 16'd0;
    case (idx_q)
      IW'(0): begin
        word = cfg_i.local_port;
        term = cfg_i.local_address[31:16];
      end
      IW'(1): begin
        word = cfg_i.remote_port;
        term = cfg_i.local_address[15:0];
      end
      IW'(2): begin
        word = job_i.seq_num[31:16];
        term = cfg_i.remote_address[31:16];
      end
      IW'(3): begin
        word = job_i.seq_num[15:0];
        term = cfg_i.remote_address[15:0];
      end
      IW'(4): begin
        word = job_i.ack_num[31:16];
        term = tshb_pkg::PROTO_TCP;
      end
      IW'(5): begin
        word = job_i.ack_num[15:0];
        term = len_total;
      end
      IW'(6): begin
        word = {tshb_pkg::DATA_OFFSET, tshb_pkg::flag_byte(job_i.seg_type)};
      end
      IW'(7): begin
        word = tshb_pkg::WINDOW;
      end
      IW'(8): begin
        word = ~acc_q;
      end
      IW'(9): begin
        word = tshb_pkg::URGENT;
      end
      default: begin
        word = 16'd0;
      end
    endcase
  end

  always_comb begin
    idx_d    = idx_q;
    acc_d    = acc_q;
    ovalid_d = ovalid_q;
    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end
    if (load) begin
      ovalid_d = 1'b1;
      acc_d    = (idx_q == tshb_pkg::IDX_LAST - IW'(1) || idx_q == tshb_pkg::IDX_LAST)
                 ? acc_q : tshb_pkg::ones_add3(acc_in, word, term);
      idx_d    = (idx_q == tshb_pkg::IDX_LAST) ? '0 : idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (load) begin
      oword_q <= word;
      oidx_q  <= idx_q;
      olast_q <= idx_q == tshb_pkg::IDX_LAST;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.header_word = oword_q;
  assign out_o.word_index  = oidx_q;
  assign out_o.header_last = olast_q;

endmodule

`default_nettype wire

### hdl/tshb_checker.sv
// Port-level checks on the header output stream, bound to the top level.
// Uses the macros in tcp_segment_header_builder_assert.svh.
`default_nettype none

`include "tcp_segment_header_builder_assert.svh"

module tshb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] out_word_i,
  input wire logic [3:0]  out_index_i,
  input wire logic        out_last_i
);

  `TSHB_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i) && $stable(out_index_i) && $stable(out_last_i), "stalled header beat changed")
  `TSHB_ASSERT(a_last_index, out_valid_i |-> (out_last_i == (out_index_i == 4'd9)), "header_last disagrees with word_index")
  `TSHB_ASSERT(a_no_gap, out_valid_i && out_ready_i && !out_last_i |=> out_valid_i && out_index_i == $past(out_index_i) + 4'd1, "header beats not contiguous")
  `TSHB_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_i, "output valid during reset")

endmodule

bind tcp_segment_header_builder tshb_checker u_tshb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.header_word),
  .out_index_i (out_o.word_index),
  .out_last_i  (out_o.header_last)
);

`default_nettype wire
